### hdl/lls_pkg.sv
`timescale 1ns / 1ps

package lls_pkg;

   localparam int CHAR_W        = 8;
   localparam int TAG_LIMIT_W   = 8;
   localparam int MSG_LIMIT_W   = 10;
   localparam int CSR_DATA_W    = 10;
   localparam int OFFSET_W      = 10;
   localparam int STAMP_W       = 32;
   localparam int RSP_DATA_W    = 80;

   localparam logic [CHAR_W-1:0] CHAR_INFO    = 8'h49;  // I
   localparam logic [CHAR_W-1:0] CHAR_WARN    = 8'h57;  // W
   localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h45;  // E
   localparam logic [CHAR_W-1:0] CHAR_DEBUG   = 8'h44;  // D
   localparam logic [CHAR_W-1:0] CHAR_VERBOSE = 8'h56;  // V
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_OPEN    = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE   = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] LEVEL_NONE   = 8'h20;

   localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;

   localparam logic [TAG_LIMIT_W-1:0] TAG_LIMIT_RESET = 8'd31;
   localparam logic [MSG_LIMIT_W-1:0] MSG_LIMIT_RESET = 10'd255;

   typedef enum logic {
      CSR_TAG_LIMIT     = 1'b0,
      CSR_MESSAGE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic header_bad;
      logic close_found;
      logic separator_found;
      logic length_overflow;
   } line_flags_type;

endpackage

### hdl/lls_line_parser.sv
`timescale 1ns / 1ps

module lls_line_parser #(
   parameter int LINE_MAX = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [lls_pkg::CHAR_W-1:0] char_in,
   input  logic                       final_char,
   output lls_pkg::line_flags_type    flags,
   output logic [lls_pkg::CHAR_W-1:0] level,
   output logic [lls_pkg::STAMP_W-1:0] stamp,
   output logic [$clog2(LINE_MAX)-1:0] close_pos,
   output logic [$clog2(LINE_MAX)-1:0] sep_pos,
   output logic [$clog2(LINE_MAX)-1:0] line_len
);
   import lls_pkg::*;

   localparam int PW = $clog2(LINE_MAX);
   localparam logic [PW-1:0] LINE_CAP = PW'(LINE_MAX - 1);

   logic [PW-1:0]      pos_ff, pos_in;
   logic               header_bad_ff, header_bad_in;
   logic [CHAR_W-1:0]  level_ff, level_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               digits_done_ff, digits_done_in;
   logic               close_found_ff, close_found_in;
   logic [PW-1:0]      close_pos_ff, close_pos_in;
   logic               prev_colon_ff, prev_colon_in;
   logic               sep_found_ff, sep_found_in;
   logic [PW-1:0]      sep_pos_ff, sep_pos_in;
   logic               overflow_ff, overflow_in;

   logic [PW:0]        pos_ext;
   logic [PW:0]        tag_base;
   logic [STAMP_W+3:0] stamp_prod;

   assign pos_ext    = {1'b0, pos_ff};
   assign tag_base   = {1'b0, close_pos_ff} + (PW+1)'(2);
   // stamp * 10 + digit, as (s << 3) + (s << 1)
   assign stamp_prod = ({4'd0, stamp_ff} << 3) + ({4'd0, stamp_ff} << 1)
                     + (STAMP_W+4)'(char_in[3:0]);

   always_comb begin
      pos_in         = pos_ff;
      header_bad_in  = header_bad_ff;
      level_in       = level_ff;
      stamp_in       = stamp_ff;
      digits_done_in = digits_done_ff;
      close_found_in = close_found_ff;
      close_pos_in   = close_pos_ff;
      prev_colon_in  = prev_colon_ff;
      sep_found_in   = sep_found_ff;
      sep_pos_in     = sep_pos_ff;
      overflow_in    = overflow_ff;
      if (step) begin
         if (pos_ff < LINE_CAP) begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(0)) begin
               if (char_in inside {CHAR_INFO, CHAR_WARN, CHAR_ERROR, CHAR_DEBUG,
                                   CHAR_VERBOSE}) begin
                  level_in = char_in;
               end else begin
                  header_bad_in = 1'b1;
               end
            end else if (pos_ff == PW'(1)) begin
               if (char_in != CHAR_SPACE) header_bad_in = 1'b1;
            end else if (pos_ff == PW'(2)) begin
               if (char_in != CHAR_OPEN) header_bad_in = 1'b1;
            end else if (!header_bad_ff) begin
               if (!close_found_ff) begin
                  if (char_in == CHAR_CLOSE) begin
                     close_found_in = 1'b1;
                     close_pos_in   = pos_ff;
                  end else if (!digits_done_ff) begin
                     if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
                        stamp_in = (stamp_prod[STAMP_W+3:STAMP_W] != 4'd0) ?
                                   STAMP_MAX : stamp_prod[STAMP_W-1:0];
                     end else begin
                        digits_done_in = 1'b1;
                     end
                  end
               end else if (pos_ext >= tag_base && !sep_found_ff) begin
                  // colon must itself sit at or after the tag start
                  if (char_in == CHAR_SPACE && prev_colon_ff &&
                      pos_ext >= tag_base + (PW+1)'(1)) begin
                     sep_found_in = 1'b1;
                     sep_pos_in   = pos_ff - PW'(1);
                  end
                  prev_colon_in = (char_in == CHAR_COLON);
               end
            end
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   assign flags.header_bad      = header_bad_in;
   assign flags.close_found     = close_found_in;
   assign flags.separator_found = sep_found_in;
   assign flags.length_overflow = overflow_in;
   assign level     = level_in;
   assign stamp     = stamp_in;
   assign close_pos = close_pos_in;
   assign sep_pos   = sep_pos_in;
   assign line_len  = pos_in;

   always_ff @(posedge clock) begin
      if (reset || (step && final_char)) begin
         pos_ff         <= '0;
         header_bad_ff  <= 1'b0;
         level_ff       <= '0;
         stamp_ff       <= '0;
         digits_done_ff <= 1'b0;
         close_found_ff <= 1'b0;
         close_pos_ff   <= '0;
         prev_colon_ff  <= 1'b0;
         sep_found_ff   <= 1'b0;
         sep_pos_ff     <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         header_bad_ff  <= header_bad_in;
         level_ff       <= level_in;
         stamp_ff       <= stamp_in;
         digits_done_ff <= digits_done_in;
         close_found_ff <= close_found_in;
         close_pos_ff   <= close_pos_in;
         prev_colon_ff  <= prev_colon_in;
         sep_found_ff   <= sep_found_in;
         sep_pos_ff     <= sep_pos_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

### hdl/lls_result.sv
`timescale 1ns / 1ps

module lls_result #(
   parameter int LINE_MAX = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  lls_pkg::line_flags_type         flags,
   input  logic [lls_pkg::CHAR_W-1:0]      level,
   input  logic [lls_pkg::STAMP_W-1:0]     stamp,
   input  logic [$clog2(LINE_MAX)-1:0]     close_pos,
   input  logic [$clog2(LINE_MAX)-1:0]     sep_pos,
   input  logic [$clog2(LINE_MAX)-1:0]     line_len,
   input  logic [lls_pkg::TAG_LIMIT_W-1:0] tag_limit,
   input  logic [lls_pkg::MSG_LIMIT_W-1:0] message_limit,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [lls_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import lls_pkg::*;

   localparam int PW = $clog2(LINE_MAX);
   localparam int CW = (PW + 1 > OFFSET_W) ? PW + 1 : OFFSET_W;

   logic          ok;
   logic [CW-1:0] len_w, tag_base, sep_w, t_off, t_len_raw, m_off, m_len_raw;
   logic [CW-1:0] tag_lim_w, msg_lim_w, t_len, m_len;

   logic                   valid_ff, valid_in;
   logic                   well_formed_ff;
   logic [CHAR_W-1:0]      level_ff;
   logic [STAMP_W-1:0]     stamp_ff;
   logic [OFFSET_W-1:0]    tag_offset_ff;
   logic [TAG_LIMIT_W-1:0] tag_length_ff;
   logic [OFFSET_W-1:0]    msg_offset_ff;
   logic [MSG_LIMIT_W-1:0] msg_length_ff;
   logic                   overlong_ff;

   assign ok        = !flags.header_bad && flags.close_found;
   assign len_w     = CW'(line_len);
   assign sep_w     = CW'(sep_pos);
   assign tag_base  = CW'(close_pos) + CW'(2);
   assign tag_lim_w = CW'(tag_limit);
   assign msg_lim_w = CW'(message_limit);

   always_comb begin
      t_off     = '0;
      t_len_raw = '0;
      if (!ok) begin
         m_off = '0;
      end else if (flags.separator_found) begin
         t_off     = tag_base;
         t_len_raw = sep_w - tag_base;
         m_off     = sep_w + CW'(2);
      end else begin
         // line may end at or just after the close paren
         m_off = (tag_base < len_w) ? tag_base : len_w;
      end
      m_len_raw = len_w - m_off;
      t_len     = (t_len_raw < tag_lim_w) ? t_len_raw : tag_lim_w;
      m_len     = (m_len_raw < msg_lim_w) ? m_len_raw : msg_lim_w;
   end

   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         well_formed_ff <= ok;
         level_ff       <= ok ? level : LEVEL_NONE;
         stamp_ff       <= ok ? stamp : '0;
         tag_offset_ff  <= OFFSET_W'(t_off);
         tag_length_ff  <= TAG_LIMIT_W'(t_len);
         msg_offset_ff  <= OFFSET_W'(m_off);
         msg_length_ff  <= MSG_LIMIT_W'(m_len);
         overlong_ff    <= flags.length_overflow;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {overlong_ff, msg_length_ff, msg_offset_ff, tag_length_ff,
                        tag_offset_ff, stamp_ff, level_ff, well_formed_ff};

endmodule

### hdl/log_line_field_splitter.sv
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register and is parsed when it
// advances; a final byte then loads the result register, which raises rsp_tvalid.
// Throughput: one byte per cycle, set by the single input register feeding the
// parser; a final byte waits only while the result register is still held.
// Reset: synchronous, clears the line state and both handshakes, and sets the
// limit registers to their defaults.

module log_line_field_splitter #(
   parameter int LINE_MAX = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] char_in
   input  logic                           req_tlast,   // final_char
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] well_formed, [8:1] level, [40:9] timestamp, [50:41] tag_offset,
   // [58:51] tag_length, [68:59] message_offset, [78:69] message_length,
   // [79] overlong
   output logic [lls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  lls_pkg::csr_index_type         csr_index,
   input  logic [lls_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lls_pkg::*;

   localparam int PW = $clog2(LINE_MAX);

   logic                   in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]      in_char_ff;
   logic                   in_last_ff;
   logic                   req_accept, advance, load;
   logic [TAG_LIMIT_W-1:0] tag_limit_ff;
   logic [MSG_LIMIT_W-1:0] msg_limit_ff;

   line_flags_type         flags;
   logic [CHAR_W-1:0]      level;
   logic [STAMP_W-1:0]     stamp;
   logic [PW-1:0]          close_pos, sep_pos, line_len;

   // only a final byte needs room in the result register
   assign advance     = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign load        = advance && in_last_ff;
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_limit_ff <= TAG_LIMIT_RESET;
         msg_limit_ff <= MSG_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAG_LIMIT:     tag_limit_ff <= csr_wdata[TAG_LIMIT_W-1:0];
            CSR_MESSAGE_LIMIT: msg_limit_ff <= csr_wdata[MSG_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   lls_line_parser #(.LINE_MAX(LINE_MAX)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_in    (in_char_ff),
      .final_char (in_last_ff),
      .flags      (flags),
      .level      (level),
      .stamp      (stamp),
      .close_pos  (close_pos),
      .sep_pos    (sep_pos),
      .line_len   (line_len)
   );

   lls_result #(.LINE_MAX(LINE_MAX)) u_result (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .flags         (flags),
      .level         (level),
      .stamp         (stamp),
      .close_pos     (close_pos),
      .sep_pos       (sep_pos),
      .line_len      (line_len),
      .tag_limit     (tag_limit_ff),
      .message_limit (msg_limit_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata)
   );

   a_load_has_room: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending transaction");

   a_stalled_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_char_ff)
                                     && $stable(in_last_ff)))
      else $error("stalled input byte lost");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a held result");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("final byte gave no result");

   a_malformed_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |->
         (rsp_tdata[8:1] == LEVEL_NONE && rsp_tdata[40:9] == '0
          && rsp_tdata[58:51] == '0 && rsp_tdata[68:59] == '0))
      else $error("malformed line with header fields set");

endmodule
